FILE: rtl/core/qbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qbw_pkg;

   localparam int COORD_BITS       = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int DIFF_W           = COORD_BITS + 1;
   localparam int PROD_W           = 2 * DIFF_W;
   localparam int TRI_W            = PROD_W + 3;
   localparam int NUM_W            = 2 * DIFF_W;
   localparam int REM_W            = NUM_W + 1;
   localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
   localparam int DIV_STEPS        = WEIGHT_W;
   localparam int LANES            = 4;
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int FRONT_STAGES     = 2;
   localparam int CSR_IDX_W        = 3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOT_RECT = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_LEFT_X     = 3'd0,
      CSR_TOP_LEFT_Y     = 3'd1,
      CSR_TOP_RIGHT_X    = 3'd2,
      CSR_TOP_RIGHT_Y    = 3'd3,
      CSR_BOTTOM_LEFT_X  = 3'd4,
      CSR_BOTTOM_LEFT_Y  = 3'd5,
      CSR_BOTTOM_RIGHT_X = 3'd6,
      CSR_BOTTOM_RIGHT_Y = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic                inside_res;
      logic [1:0]          status;
      logic [WEIGHT_W-1:0] weight_top_left;
      logic [WEIGHT_W-1:0] weight_top_right;
      logic [WEIGHT_W-1:0] weight_bottom_left;
      logic [WEIGHT_W-1:0] weight_bottom_right;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] top_left_x;
      logic signed [COORD_BITS-1:0] top_left_y;
      logic signed [COORD_BITS-1:0] top_right_x;
      logic signed [COORD_BITS-1:0] top_right_y;
      logic signed [COORD_BITS-1:0] bottom_left_x;
      logic signed [COORD_BITS-1:0] bottom_left_y;
      logic signed [COORD_BITS-1:0] bottom_right_x;
      logic signed [COORD_BITS-1:0] bottom_right_y;
   } quad_type;

   typedef struct packed {
      logic                        in_quad;
      status_type                  status;
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [NUM_W-1:0]            den;
   } qent_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic almost_full;
   } qstat_type;

endpackage
`default_nettype wire

FILE: rtl/core/quad_bilinear_weights.sv
// quad_bilinear_weights
// point-in-quad test and bilinear corner weights for a configured mesh quad
// csr channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//   always high, indexes 0..7 pick the eight corner coordinates (signed q12.4)
// req channel: a word (point_x, point_y) is taken at each clock edge with
//   start high and busy low
// rsp channel: rsp_valid strobes for one cycle with the result word; the
//   receiver cannot stall, so results are never held
// a word passes front stages a and b, the queue, the divider stages and the output register
// throughput: one word per cycle while busy is low; the front computes differences and
//   products in two stages, a 4-entry queue feeds the back, whose 17-stage
//   restoring divider pipeline produces one quotient bit per stage and lane
// busy rises only when the queue nears full, which does not happen in
//   steady streaming since the back pops every cycle
// reset: synchronous; clears the corner registers to zero, empties the
//   queue and drops all words in flight
// configuration must be written only while no word is in flight; the block does not enforce it
`timescale 1ns / 1ps
`default_nettype none
module quad_bilinear_weights
   import qbw_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  req_type               req_word,
   output logic                  rsp_valid,
   output rsp_type               rsp_word,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [COORD_BITS-1:0] csr_data
);

   quad_type  quad_ff, quad_in;
   logic      accept;
   logic      push;
   qent_type  push_word;
   qent_type  head;
   qstat_type qstat;

   assign csr_ready = 1'b1;
   assign busy      = qstat.almost_full;
   assign accept    = start && !busy;

   always_comb begin
      quad_in = quad_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TOP_LEFT_X:     quad_in.top_left_x     = csr_data;
            CSR_TOP_LEFT_Y:     quad_in.top_left_y     = csr_data;
            CSR_TOP_RIGHT_X:    quad_in.top_right_x    = csr_data;
            CSR_TOP_RIGHT_Y:    quad_in.top_right_y    = csr_data;
            CSR_BOTTOM_LEFT_X:  quad_in.bottom_left_x  = csr_data;
            CSR_BOTTOM_LEFT_Y:  quad_in.bottom_left_y  = csr_data;
            CSR_BOTTOM_RIGHT_X: quad_in.bottom_right_x = csr_data;
            CSR_BOTTOM_RIGHT_Y: quad_in.bottom_right_y = csr_data;
            default:            quad_in = quad_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff <= '0;
      end else begin
         quad_ff <= quad_in;
      end
   end

   qbw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .quad      (quad_ff),
      .push      (push),
      .push_word (push_word)
   );

   qbw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (!qstat.empty),
      .head      (head),
      .qstat     (qstat)
   );

   qbw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!qstat.empty),
      .head       (head),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("queue overflow");

   a_ok_inside : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == STATUS_OK) |-> rsp_word.inside_res)
      else $error("ok status without inside point");

   a_zero_weights : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != STATUS_OK) |->
      (rsp_word.weight_top_left == '0 && rsp_word.weight_top_right == '0
       && rsp_word.weight_bottom_left == '0 && rsp_word.weight_bottom_right == '0))
      else $error("nonzero weights without ok status");

   a_weight_sum : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((WEIGHT_W + 2)'(rsp_word.weight_top_left)
                     + (WEIGHT_W + 2)'(rsp_word.weight_top_right)
                     + (WEIGHT_W + 2)'(rsp_word.weight_bottom_left)
                     + (WEIGHT_W + 2)'(rsp_word.weight_bottom_right)
                     <= (WEIGHT_W + 2)'(1 << WEIGHT_FRAC_BITS)))
      else $error("weights sum above one");

endmodule
`default_nettype wire

FILE: rtl/core/qbw_front.sv
`timescale 1ns / 1ps
`default_nettype none
module qbw_front
   import qbw_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      accept,
   input  req_type  req_word,
   input  quad_type quad,
   output logic     push,
   output qent_type push_word
);

   function automatic logic signed [DIFF_W-1:0] diff(logic signed [COORD_BITS-1:0] a,
                                                    logic signed [COORD_BITS-1:0] b);
      diff = DIFF_W'(a) - DIFF_W'(b);
   endfunction

   function automatic logic [DIFF_W-1:0] mag(logic signed [DIFF_W-1:0] v);
      mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   function automatic logic in_tri(logic signed [TRI_W-1:0] den,
                                   logic signed [TRI_W-1:0] n1,
                                   logic signed [TRI_W-1:0] n2);
      logic signed [TRI_W-1:0] n3;
      logic signed [TRI_W-1:0] e1;
      logic signed [TRI_W-1:0] e2;
      logic signed [TRI_W-1:0] e3;
      logic                    pos;
      logic                    neg;
      n3  = den - n1 - n2;
      e1  = den - n1;
      e2  = den - n2;
      e3  = n1 + n2;
      pos = (n1 >= 0) && (n2 >= 0) && (n3 >= 0) && (e1 >= 0) && (e2 >= 0) && (e3 >= 0);
      neg = (n1 <= 0) && (n2 <= 0) && (n3 <= 0) && (e1 <= 0) && (e2 <= 0) && (e3 <= 0);
      if (den > 0) begin
         in_tri = pos;
      end else if (den < 0) begin
         in_tri = neg;
      end else begin
         in_tri = 1'b0;
      end
   endfunction

   // stage a: coordinate differences, their magnitudes and the rectangle check
   logic                     va_ff;
   logic signed [DIFF_W-1:0] d1_ff [2], d1_in [2];
   logic signed [DIFF_W-1:0] d2_ff [2], d2_in [2];
   logic signed [DIFF_W-1:0] ex_ff, ex_in, ey_ff, ey_in, qx_ff, qx_in, qy_ff, qy_in;
   logic signed [DIFF_W-1:0] d3_ff, d3_in;
   logic [DIFF_W-1:0]        wax_ff, wax_in, wbx_ff, wbx_in, way_ff, way_in, wby_ff, wby_in;
   logic [DIFF_W-1:0]        wdx_ff, wdx_in, wdy_ff, wdy_in;
   logic                     rect_ff, rect_in;

   // stage b: products
   logic                     vb_ff;
   logic signed [PROD_W-1:0] pa_ff [2], pb_ff [2], pc_ff [2], pd_ff [2];
   logic signed [PROD_W-1:0] pe_ff, pf_ff;
   logic [NUM_W-1:0]         num_ff [LANES];
   logic [NUM_W-1:0]         den_ff;
   logic                     rectb_ff;

   logic                     ins0, ins1, in_quad;

   always_comb begin
      d1_in[0] = diff(quad.top_right_y, quad.bottom_right_y);
      d2_in[0] = diff(quad.bottom_right_x, quad.top_right_x);
      d1_in[1] = diff(quad.bottom_left_y, quad.bottom_right_y);
      d2_in[1] = diff(quad.bottom_right_x, quad.bottom_left_x);
      ex_in    = diff(quad.top_left_x, quad.bottom_right_x);
      ey_in    = diff(quad.top_left_y, quad.bottom_right_y);
      qx_in    = diff(req_word.point_x, quad.bottom_right_x);
      qy_in    = diff(req_word.point_y, quad.bottom_right_y);
      d3_in    = diff(quad.bottom_right_y, quad.top_left_y);
      wax_in   = mag(diff(quad.top_right_x, req_word.point_x));
      wbx_in   = mag(diff(req_word.point_x, quad.top_left_x));
      way_in   = mag(diff(quad.bottom_left_y, req_word.point_y));
      wby_in   = mag(diff(req_word.point_y, quad.top_left_y));
      wdx_in   = mag(diff(quad.top_right_x, quad.top_left_x));
      wdy_in   = mag(diff(quad.bottom_left_y, quad.top_left_y));
      rect_in  = (quad.top_left_x == quad.bottom_left_x)
              && (quad.top_right_x == quad.bottom_right_x)
              && (quad.top_left_y == quad.top_right_y)
              && (quad.bottom_left_y == quad.bottom_right_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
      end
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      d3_ff   <= d3_in;
      wax_ff  <= wax_in;
      wbx_ff  <= wbx_in;
      way_ff  <= way_in;
      wby_ff  <= wby_in;
      wdx_ff  <= wdx_in;
      wdy_ff  <= wdy_in;
      rect_ff <= rect_in;
      for (int t = 0; t < 2; t++) begin
         pa_ff[t] <= d1_ff[t] * ex_ff;
         pb_ff[t] <= d2_ff[t] * ey_ff;
         pc_ff[t] <= d1_ff[t] * qx_ff;
         pd_ff[t] <= d2_ff[t] * qy_ff;
      end
      pe_ff     <= d3_ff * qx_ff;
      pf_ff     <= ex_ff * qy_ff;
      num_ff[0] <= wax_ff * way_ff;
      num_ff[1] <= wbx_ff * way_ff;
      num_ff[2] <= wax_ff * wby_ff;
      num_ff[3] <= wbx_ff * wby_ff;
      den_ff    <= wdx_ff * wdy_ff;
      rectb_ff  <= rect_ff;
   end

   always_comb begin
      ins0    = in_tri(TRI_W'(pa_ff[0]) + TRI_W'(pb_ff[0]),
                       TRI_W'(pc_ff[0]) + TRI_W'(pd_ff[0]),
                       TRI_W'(pe_ff) + TRI_W'(pf_ff));
      ins1    = in_tri(TRI_W'(pa_ff[1]) + TRI_W'(pb_ff[1]),
                       TRI_W'(pc_ff[1]) + TRI_W'(pd_ff[1]),
                       TRI_W'(pe_ff) + TRI_W'(pf_ff));
      in_quad = ins0 || ins1;
      push    = vb_ff;
      push_word.in_quad = in_quad;
      if (!rectb_ff) begin
         push_word.status = STATUS_NOT_RECT;
      end else if (!in_quad) begin
         push_word.status = STATUS_OUTSIDE;
      end else begin
         push_word.status = STATUS_OK;
      end
      for (int l = 0; l < LANES; l++) begin
         push_word.num[l] = num_ff[l];
      end
      push_word.den = den_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/core/qbw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module qbw_queue
   import qbw_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  wire       push,
   input  qent_type  push_word,
   input  wire       pop,
   output qent_type  head,
   output qstat_type qstat
);

   qent_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
      head   = slot_ff[rd_ff];
      qstat.empty       = (cnt_ff == '0);
      qstat.full        = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
      qstat.almost_full = (cnt_ff >= FIFO_CNT_W'(FIFO_DEPTH - FRONT_STAGES));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/qbw_back.sv
`timescale 1ns / 1ps
`default_nettype none
module qbw_back
   import qbw_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      head_valid,
   input  qent_type head,
   output logic     rsp_valid,
   output rsp_type  rsp_word
);

   // one restoring division step, returns {quotient bit, remainder}
   function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem,
                                              logic [NUM_W-1:0] den,
                                              logic             shift);
      logic [REM_W-1:0] r;
      logic             bit_q;
      r     = shift ? {rem[REM_W-2:0], 1'b0} : rem;
      bit_q = (r >= REM_W'(den));
      if (bit_q) begin
         r = r - REM_W'(den);
      end
      div_step = {bit_q, r};
   endfunction

   logic [DIV_STEPS-1:0] v_ff, v_in;
   status_type           st_ff  [DIV_STEPS], st_in  [DIV_STEPS];
   logic                 ins_ff [DIV_STEPS], ins_in [DIV_STEPS];
   logic [NUM_W-1:0]     den_ff [DIV_STEPS], den_in [DIV_STEPS];
   logic [REM_W-1:0]     rem_ff [DIV_STEPS][LANES], rem_in [DIV_STEPS][LANES];
   logic [WEIGHT_W-1:0]  q_ff   [DIV_STEPS][LANES], q_in   [DIV_STEPS][LANES];
   logic                 rsp_valid_ff;
   rsp_type              rsp_word_ff, rsp_word_in;

   always_comb begin
      logic [REM_W-1:0]    src_rem;
      logic [WEIGHT_W-1:0] src_q;
      logic [REM_W:0]      step;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            v_in[k]   = head_valid;
            st_in[k]  = head.status;
            ins_in[k] = head.in_quad;
            den_in[k] = head.den;
         end else begin
            v_in[k]   = v_ff[k-1];
            st_in[k]  = st_ff[k-1];
            ins_in[k] = ins_ff[k-1];
            den_in[k] = den_ff[k-1];
         end
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               src_rem = REM_W'(head.num[l]);
               src_q   = '0;
            end else begin
               src_rem = rem_ff[k-1][l];
               src_q   = q_ff[k-1][l];
            end
            step         = div_step(src_rem, den_in[k], (k != 0));
            rem_in[k][l] = step[REM_W-1:0];
            q_in[k][l]   = {src_q[WEIGHT_W-2:0], step[REM_W]};
         end
      end
   end

   always_comb begin
      rsp_word_in.inside_res = ins_ff[DIV_STEPS-1];
      rsp_word_in.status     = st_ff[DIV_STEPS-1];
      if (st_ff[DIV_STEPS-1] == STATUS_OK) begin
         rsp_word_in.weight_top_left     = q_ff[DIV_STEPS-1][0];
         rsp_word_in.weight_top_right    = q_ff[DIV_STEPS-1][1];
         rsp_word_in.weight_bottom_left  = q_ff[DIV_STEPS-1][2];
         rsp_word_in.weight_bottom_right = q_ff[DIV_STEPS-1][3];
      end else begin
         rsp_word_in.weight_top_left     = '0;
         rsp_word_in.weight_top_right    = '0;
         rsp_word_in.weight_bottom_left  = '0;
         rsp_word_in.weight_bottom_right = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= v_in;
         rsp_valid_ff <= v_ff[DIV_STEPS-1];
      end
      st_ff       <= st_in;
      ins_ff      <= ins_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import qbw_pkg::*;

   localparam int LATENCY = 21;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_word;
   logic rsp_valid;
   rsp_type rsp_word;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_BITS-1:0] csr_data;

   quad_bilinear_weights u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   typedef struct {
      req_type pt;
      logic    typed;
      rsp_type rsp;
   } stim_row_type;

   quad_type   quad;
   rsp_type    expected_q[$];
   int         n_errors = 0;
   int         n_checked = 0;
   int         n_ok = 0;
   int         n_outside = 0;
   int         n_notrect = 0;
   int         n_quads = 0;
   stim_row_type dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // exact signed triangle test, boundary included, degenerate is outside
   function automatic logic in_tri(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by, longint cx, longint cy);
      longint d1, d2, ex, ey, qx, qy, d3, den, n1, n2, n3;
      d1 = by - cy; d2 = cx - bx; ex = ax - cx; ey = ay - cy;
      qx = px - cx; qy = py - cy; d3 = cy - ay;
      den = d1 * ex + d2 * ey;
      n1 = d1 * qx + d2 * qy;
      n2 = d3 * qx + ex * qy;
      n3 = den - n1 - n2;
      if (den == 0) return 1'b0;
      if (den < 0) begin
         den = -den; n1 = -n1; n2 = -n2; n3 = -n3;
      end
      return n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den && n3 >= 0 && n3 <= den;
   endfunction

   function automatic logic [WEIGHT_W-1:0] weight_of(longint num, longint den);
      logic [127:0] q;
      if (den == 0) return '0;
      q = (128'(num) << WEIGHT_FRAC_BITS) / 128'(den);
      return q[WEIGHT_W-1:0];
   endfunction

   function automatic longint absv(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic rsp_type predict_weights(req_type p);
      rsp_type r;
      longint px, py, x1, x2, y1, y2, ax, bx, ay, by, den;
      logic in_quad, rect;
      px = p.point_x; py = p.point_y;
      in_quad = in_tri(px, py, quad.top_left_x, quad.top_left_y, quad.top_right_x,
                       quad.top_right_y, quad.bottom_right_x, quad.bottom_right_y)
             || in_tri(px, py, quad.top_left_x, quad.top_left_y, quad.bottom_left_x,
                       quad.bottom_left_y, quad.bottom_right_x, quad.bottom_right_y);
      rect = quad.top_left_x == quad.bottom_left_x && quad.top_right_x == quad.bottom_right_x
          && quad.top_left_y == quad.top_right_y
          && quad.bottom_left_y == quad.bottom_right_y;
      r = '0;
      r.inside_res = in_quad;
      if (!rect) begin
         r.status = STATUS_NOT_RECT;
      end else if (!in_quad) begin
         r.status = STATUS_OUTSIDE;
      end else begin
         r.status = STATUS_OK;
         x1 = quad.top_left_x; x2 = quad.top_right_x;
         y1 = quad.top_left_y; y2 = quad.bottom_left_y;
         ax = absv(x2 - px); bx = absv(px - x1);
         ay = absv(y2 - py); by = absv(py - y1);
         den = absv(x2 - x1) * absv(y2 - y1);
         r.weight_top_left     = weight_of(ax * ay, den);
         r.weight_top_right    = weight_of(bx * ay, den);
         r.weight_bottom_left  = weight_of(ax * by, den);
         r.weight_bottom_right = weight_of(bx * by, den);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected");
            n_errors++;
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            case (e.status)
               STATUS_OK:       n_ok++;
               STATUS_NOT_RECT: n_notrect++;
               default:         n_outside++;
            endcase
            if (rsp_word.inside_res !== e.inside_res) begin
               $error("inside_res exp %0d got %0d", e.inside_res, rsp_word.inside_res);
               n_errors++;
            end
            if (rsp_word.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_word.status);
               n_errors++;
            end
            if (rsp_word.weight_top_left !== e.weight_top_left) begin
               $error("weight_top_left exp %0d got %0d", e.weight_top_left,
                      rsp_word.weight_top_left);
               n_errors++;
            end
            if (rsp_word.weight_top_right !== e.weight_top_right) begin
               $error("weight_top_right exp %0d got %0d", e.weight_top_right,
                      rsp_word.weight_top_right);
               n_errors++;
            end
            if (rsp_word.weight_bottom_left !== e.weight_bottom_left) begin
               $error("weight_bottom_left exp %0d got %0d", e.weight_bottom_left,
                      rsp_word.weight_bottom_left);
               n_errors++;
            end
            if (rsp_word.weight_bottom_right !== e.weight_bottom_right) begin
               $error("weight_bottom_right exp %0d got %0d", e.weight_bottom_right,
                      rsp_word.weight_bottom_right);
               n_errors++;
            end
         end
      end
   end

   task automatic write_csr(csr_idx_type idx, logic [COORD_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TOP_LEFT_X:     quad.top_left_x = val;
         CSR_TOP_LEFT_Y:     quad.top_left_y = val;
         CSR_TOP_RIGHT_X:    quad.top_right_x = val;
         CSR_TOP_RIGHT_Y:    quad.top_right_y = val;
         CSR_BOTTOM_LEFT_X:  quad.bottom_left_x = val;
         CSR_BOTTOM_LEFT_Y:  quad.bottom_left_y = val;
         CSR_BOTTOM_RIGHT_X: quad.bottom_right_x = val;
         default:            quad.bottom_right_y = val;
      endcase
   endtask

   task automatic load_quad(quad_type q);
      write_csr(CSR_TOP_LEFT_X, q.top_left_x);
      write_csr(CSR_TOP_LEFT_Y, q.top_left_y);
      write_csr(CSR_TOP_RIGHT_X, q.top_right_x);
      write_csr(CSR_TOP_RIGHT_Y, q.top_right_y);
      write_csr(CSR_BOTTOM_LEFT_X, q.bottom_left_x);
      write_csr(CSR_BOTTOM_LEFT_Y, q.bottom_left_y);
      write_csr(CSR_BOTTOM_RIGHT_X, q.bottom_right_x);
      write_csr(CSR_BOTTOM_RIGHT_Y, q.bottom_right_y);
      csr_valid <= 1'b0;
      n_quads++;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      while (expected_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one word per call; gap drawn per word, sometimes zero for back-to-back
   task automatic send_point(req_type p, logic typed, rsp_type r, logic idle_ok);
      int gap;
      gap = idle_ok && ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= p;
      do @(posedge clock); while (busy);
      expected_q.push_back(typed ? r : predict_weights(p));
   endtask

   task automatic add_row(logic signed [15:0] x, logic signed [15:0] y, logic typed,
                          rsp_type r);
      stim_row_type s;
      s.pt.point_x = x; s.pt.point_y = y; s.typed = typed; s.rsp = r;
      dir_rows.push_back(s);
   endtask

   function automatic rsp_type status_only(logic ins, status_type st);
      rsp_type r;
      r = '0; r.inside_res = ins; r.status = st;
      return r;
   endfunction

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed($urandom_range(0, 1023)) - 512);
      endcase
   endfunction

   function automatic quad_type rand_quad();
      quad_type q;
      logic signed [15:0] xa, xb, ya, yb;
      int kind;
      kind = $urandom_range(0, 9);
      xa = rand_coord(); xb = rand_coord(); ya = rand_coord(); yb = rand_coord();
      if (kind == 0) xb = xa;
      if (kind < 7) begin
         q.top_left_x = xa; q.bottom_left_x = xa;
         q.top_right_x = xb; q.bottom_right_x = xb;
         q.top_left_y = ya; q.top_right_y = ya;
         q.bottom_left_y = yb; q.bottom_right_y = yb;
      end else begin
         q = quad_type'({$urandom, $urandom, $urandom, $urandom});
         if (kind == 7) begin
            q.top_left_x = xa; q.top_left_y = ya; q.top_right_x = xb;
            q.top_right_y = ya; q.bottom_left_x = xa; q.bottom_left_y = yb;
            q.bottom_right_x = xb + 16'sd1; q.bottom_right_y = yb;
         end
      end
      return q;
   endfunction

   function automatic req_type rand_point();
      req_type p;
      longint lx, hx, ly, hy;
      lx = quad.top_left_x < quad.top_right_x ? quad.top_left_x : quad.top_right_x;
      hx = quad.top_left_x < quad.top_right_x ? quad.top_right_x : quad.top_left_x;
      ly = quad.top_left_y < quad.bottom_left_y ? quad.top_left_y : quad.bottom_left_y;
      hy = quad.top_left_y < quad.bottom_left_y ? quad.bottom_left_y : quad.top_left_y;
      case ($urandom_range(0, 9))
         0, 1: p = req_type'($urandom);
         2: begin
            p.point_x = $urandom_range(0, 1) ? lx : hx;
            p.point_y = 16'(ly + longint'($urandom_range(0, 32'(hy - ly))));
         end
         3: begin
            p.point_x = 16'(lx + longint'($urandom_range(0, 32'(hx - lx))));
            p.point_y = $urandom_range(0, 1) ? ly : hy;
         end
         default: begin
            p.point_x = 16'(lx + longint'($urandom_range(0, 32'(hx - lx))));
            p.point_y = 16'(ly + longint'($urandom_range(0, 32'(hy - ly))));
         end
      endcase
      return p;
   endfunction

   initial begin
      quad_type q;
      rsp_type  r;
      int       phase;
      reset     = 1'b1;
      start     = 1'b0;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      quad      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset quad is all zeros: degenerate, counts as a rectangle
      add_row(16'sd0, 16'sd0, 1'b1, status_only(1'b0, STATUS_OUTSIDE));
      add_row(16'sh7fff, 16'sh8000, 1'b1, status_only(1'b0, STATUS_OUTSIDE));
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed,
                                       dir_rows[i].rsp, 1'b0);
      start <= 1'b0;
      wait_drained();
      dir_rows.delete();

      // full-range rectangle, corners and center
      q.top_left_x = 16'sh8000; q.top_left_y = 16'sh8000;
      q.top_right_x = 16'sh7fff; q.top_right_y = 16'sh8000;
      q.bottom_left_x = 16'sh8000; q.bottom_left_y = 16'sh7fff;
      q.bottom_right_x = 16'sh7fff; q.bottom_right_y = 16'sh7fff;
      load_quad(q);
      r = '0; r.inside_res = 1'b1; r.status = STATUS_OK; r.weight_top_left = 17'h10000;
      add_row(16'sh8000, 16'sh8000, 1'b1, r);
      r = '0; r.inside_res = 1'b1; r.status = STATUS_OK;
      r.weight_bottom_right = 17'h10000;
      add_row(16'sh7fff, 16'sh7fff, 1'b1, r);
      add_row(16'sh7fff, 16'sh8000, 1'b0, r);
      add_row(16'sh8000, 16'sh7fff, 1'b0, r);
      add_row(16'sd0, 16'sd0, 1'b0, r);
      add_row(-16'sd1, 16'sd1, 1'b0, r);
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed,
                                       dir_rows[i].rsp, 1'b1);
      start <= 1'b0;
      wait_drained();
      dir_rows.delete();

      // flipped rectangle, points inside, on edges and outside
      q.top_left_x = 16'sd160; q.top_left_y = 16'sd80;
      q.top_right_x = -16'sd48; q.top_right_y = 16'sd80;
      q.bottom_left_x = 16'sd160; q.bottom_left_y = -16'sd33;
      q.bottom_right_x = -16'sd48; q.bottom_right_y = -16'sd33;
      load_quad(q);
      add_row(16'sd0, 16'sd0, 1'b0, r);
      add_row(16'sd160, 16'sd3, 1'b0, r);
      add_row(-16'sd48, -16'sd33, 1'b0, r);
      add_row(16'sd161, 16'sd0, 1'b1, status_only(1'b0, STATUS_OUTSIDE));
      add_row(16'sd0, 16'sd81, 1'b1, status_only(1'b0, STATUS_OUTSIDE));
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed,
                                       dir_rows[i].rsp, 1'b1);
      start <= 1'b0;
      wait_drained();
      dir_rows.delete();

      // skewed quad: not a rectangle, inside still reported
      q.bottom_right_x = -16'sd50;
      load_quad(q);
      add_row(16'sd0, 16'sd0, 1'b1, status_only(1'b1, STATUS_NOT_RECT));
      add_row(16'sh7fff, 16'sh7fff, 1'b1, status_only(1'b0, STATUS_NOT_RECT));
      add_row(16'sd10, -16'sd10, 1'b0, r);
      foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed,
                                       dir_rows[i].rsp, 1'b1);
      start <= 1'b0;
      wait_drained();

      for (phase = 0; phase < 22; phase++) begin
         load_quad(rand_quad());
         for (int k = 0; k < 50; k++) begin
            // one pause per phase until the pipeline empties
            if (k == 25) begin
               start <= 1'b0;
               wait_drained();
            end
            send_point(rand_point(), 1'b0, r, phase % 3 != 0);
         end
         start <= 1'b0;
         wait_drained();
      end

      $display("covered %0d quads, %0d results: %0d ok, %0d outside, %0d not rectangle",
               n_quads, n_checked, n_ok, n_outside, n_notrect);
      if (n_errors == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/qbw_pkg.sv
rtl/core/qbw_front.sv
rtl/core/qbw_queue.sv
rtl/core/qbw_back.sv
rtl/core/quad_bilinear_weights.sv
sim/tb_top.sv
